FILE: rtl/assert_macros.svh
// assertion helpers, clk and rst_n taken from the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mmbd_pkg.sv
package mmbd_pkg;

    localparam int BOOT_ROM_BYTES = 256;
    localparam int BOOT_IDX_W     = $clog2(BOOT_ROM_BYTES);
    localparam int STORE_DEPTH    = 65536;

    localparam logic [1:0] FN_READ  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_LOAD  = 2'd2;

    localparam logic [1:0] ST_LOCAL = 2'd0;
    localparam logic [1:0] ST_FWD   = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    localparam logic [15:0] ADDR_ROM_END    = 16'h8000;
    localparam logic [15:0] ADDR_VRAM_END   = 16'hA000;
    localparam logic [15:0] ADDR_MIRROR_LO  = 16'hE000;
    localparam logic [15:0] ADDR_MIRROR_END = 16'hFE00;
    localparam logic [15:0] MIRROR_OFFSET   = 16'h2000;
    localparam logic [15:0] ADDR_UNUSED_LO  = 16'hFEA0;
    localparam logic [15:0] ADDR_IO_LO      = 16'hFF00;
    localparam logic [15:0] ADDR_IF         = 16'hFF0F;
    localparam logic [15:0] ADDR_LCD_LO     = 16'hFF40;
    localparam logic [15:0] ADDR_LCD_HI     = 16'hFF44;
    localparam logic [15:0] ADDR_BGP        = 16'hFF47;
    localparam logic [15:0] ADDR_BOOT_OFF   = 16'hFF50;
    localparam logic [15:0] ADDR_IE         = 16'hFFFF;

    localparam logic [7:0] FAULT_BYTE = 8'hFF;

    localparam logic [7:0] BOOT_TABLE [BOOT_ROM_BYTES] = '{
        8'h31, 8'hFE, 8'hFF, 8'hAF, 8'h21, 8'hFF, 8'h9F, 8'h32,
        8'hCB, 8'h7C, 8'h20, 8'hFB, 8'h21, 8'h26, 8'hFF, 8'h0E,
        8'h11, 8'h3E, 8'h80, 8'h32, 8'hE2, 8'h0C, 8'h3E, 8'hF3,
        8'hE2, 8'h32, 8'h3E, 8'h77, 8'h77, 8'h3E, 8'hFC, 8'hE0,
        8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1A,
        8'hCD, 8'h95, 8'h00, 8'hCD, 8'h96, 8'h00, 8'h13, 8'h7B,
        8'hFE, 8'h34, 8'h20, 8'hF3, 8'h11, 8'hD8, 8'h00, 8'h06,
        8'h08, 8'h1A, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hF9,
        8'h3E, 8'h19, 8'hEA, 8'h10, 8'h99, 8'h21, 8'h2F, 8'h99,
        8'h0E, 8'h0C, 8'h3D, 8'h28, 8'h08, 8'h32, 8'h0D, 8'h20,
        8'hF9, 8'h2E, 8'h0F, 8'h18, 8'hF3, 8'h67, 8'h3E, 8'h64,
        8'h57, 8'hE0, 8'h42, 8'h3E, 8'h91, 8'hE0, 8'h40, 8'h04,
        8'h1E, 8'h02, 8'h0E, 8'h0C, 8'hF0, 8'h44, 8'hFE, 8'h90,
        8'h20, 8'hFA, 8'h0D, 8'h20, 8'hF7, 8'h1D, 8'h20, 8'hF2,
        8'h0E, 8'h13, 8'h24, 8'h7C, 8'h1E, 8'h83, 8'hFE, 8'h62,
        8'h28, 8'h06, 8'h1E, 8'hC1, 8'hFE, 8'h64, 8'h20, 8'h06,
        8'h7B, 8'hE2, 8'h0C, 8'h3E, 8'h87, 8'hE2, 8'hF0, 8'h42,
        8'h90, 8'hE0, 8'h42, 8'h15, 8'h20, 8'hD2, 8'h05, 8'h20,
        8'h4F, 8'h16, 8'h20, 8'h18, 8'hCB, 8'h4F, 8'h06, 8'h04,
        8'hC5, 8'hCB, 8'h11, 8'h17, 8'hC1, 8'hCB, 8'h11, 8'h17,
        8'h05, 8'h20, 8'hF5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hC9,
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
        8'h3C, 8'h42, 8'hB9, 8'hA5, 8'hB9, 8'hA5, 8'h42, 8'h3C,
        8'h21, 8'h04, 8'h01, 8'h11, 8'hA8, 8'h00, 8'h1A, 8'h13,
        8'hBE, 8'h20, 8'hFE, 8'h23, 8'h7D, 8'hFE, 8'h34, 8'h20,
        8'hF5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
        8'hFB, 8'h86, 8'h20, 8'hFE, 8'h3E, 8'h01, 8'hE0, 8'h50
    };

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  rd_byte;
        logic [15:0] fwd_addr;
        logic [7:0]  fwd_byte;
        logic        sel_store;
        logic        ram_en;
        logic        ram_we;
        logic [15:0] ram_addr;
        logic        set_flag;
        logic        set_enable;
        logic        set_overlay;
        logic        overlay_val;
    } dec_t;

endpackage

FILE: rtl/mmbd_req_if.sv
interface mmbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_byte;

    modport source (output valid, output func, output address, output write_byte, input ready);
    modport sink (input valid, input func, input address, input write_byte, output ready);
endinterface

FILE: rtl/mmbd_rsp_if.sv
interface mmbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_byte;
    logic [1:0]  status;
    logic [15:0] forward_address;
    logic [7:0]  forward_byte;

    modport source (output valid, output read_byte, output status, output forward_address,
                    output forward_byte, input ready);
    modport sink (input valid, input read_byte, input status, input forward_address,
                  input forward_byte, output ready);
endinterface

FILE: rtl/memory_map_bus_decoder.sv
// channel  | dir | handshake     | beat payload
// ---------+-----+---------------+-------------------------------------------------
// req      | in  | valid / ready | func, address, write_byte
// rsp      | out | valid / ready | read_byte, status, forward_address, forward_byte
// apb      | in  | psel/penable  | paddr, pwdata, prdata (skip_boot_rom at 0)
//
// one beat per cycle sustained while rsp.ready stays high; a result goes from its request beat
// into the stage registers and the byte store read port, and from there into the output register
// rsp.ready low holds the result; one more request is taken and parked, then req.ready drops
// rst_n clears control registers and the overlay comes up on; the byte store is not cleared
module memory_map_bus_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mmbd_req_if.sink    req,
    mmbd_rsp_if.source  rsp
);
    import mmbd_pkg::*;
    `include "assert_macros.svh"

    dec_t        dec;
    logic        in_acc;
    logic        can_load;
    logic        cfg_wr;
    logic [7:0]  ram_rdata;

    logic        skip_reg;
    logic        skip_next;
    logic        overlay_reg;
    logic        overlay_next;
    logic [7:0]  irq_flag_reg;
    logic [7:0]  irq_flag_next;
    logic [7:0]  irq_enable_reg;
    logic [7:0]  irq_enable_next;
    logic        busy_reg;
    logic        busy_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [1:0]  st_status_reg;
    logic [7:0]  st_byte_reg;
    logic [15:0] st_faddr_reg;
    logic [7:0]  st_fbyte_reg;
    logic        st_sel_store_reg;

    logic [7:0]  out_byte_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_faddr_reg;
    logic [7:0]  out_fbyte_reg;

    mmbd_decode u_decode (
        .func       (req.func),
        .address    (req.address),
        .write_byte (req.write_byte),
        .overlay_on (overlay_reg),
        .irq_flag   (irq_flag_reg),
        .irq_enable (irq_enable_reg),
        .dec        (dec)
    );

    mmbd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (in_acc && dec.ram_en),
        .we    (dec.ram_we),
        .addr  (dec.ram_addr),
        .wdata (req.write_byte),
        .rdata (ram_rdata)
    );

    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, skip_reg} : 32'd0;

    assign can_load  = !out_valid_reg || rsp.ready;
    assign req.ready = !busy_reg || can_load;
    assign in_acc    = req.valid && req.ready;

    always_comb
    begin
        skip_next       = cfg_wr ? pwdata[0] : skip_reg;
        irq_flag_next   = (in_acc && dec.set_flag) ? req.write_byte : irq_flag_reg;
        irq_enable_next = (in_acc && dec.set_enable) ? req.write_byte : irq_enable_reg;
        overlay_next    = overlay_reg;
        if (cfg_wr && pwdata[0])
        begin
            overlay_next = 1'b0;
        end
        else if (in_acc && dec.set_overlay)
        begin
            overlay_next = dec.overlay_val;
        end
        busy_next = busy_reg;
        if (in_acc)
        begin
            busy_next = 1'b1;
        end
        else if (can_load)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (busy_reg && can_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg       <= 1'b0;
            overlay_reg    <= 1'b1;
            irq_flag_reg   <= 8'h00;
            irq_enable_reg <= 8'h00;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            skip_reg       <= skip_next;
            overlay_reg    <= overlay_next;
            irq_flag_reg   <= irq_flag_next;
            irq_enable_reg <= irq_enable_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            st_status_reg    <= dec.status;
            st_byte_reg      <= dec.rd_byte;
            st_faddr_reg     <= dec.fwd_addr;
            st_fbyte_reg     <= dec.fwd_byte;
            st_sel_store_reg <= dec.sel_store;
        end
        if (busy_reg && can_load)
        begin
            out_byte_reg   <= st_sel_store_reg ? ram_rdata : st_byte_reg;
            out_status_reg <= st_status_reg;
            out_faddr_reg  <= st_faddr_reg;
            out_fbyte_reg  <= st_fbyte_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.read_byte       = out_byte_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.forward_address = out_faddr_reg;
    assign rsp.forward_byte    = out_fbyte_reg;

    // a fault beat carries only the fault byte
    `ASSERT_IMPL(a_fault_fields, out_valid_reg && out_status_reg == ST_FAULT,
        out_byte_reg == FAULT_BYTE && out_faddr_reg == 16'd0 && out_fbyte_reg == 8'd0,
        "fault result carries data")
    // store reads land in the stage with the store select set
    `ASSERT_NEXT(a_store_read_stage, in_acc && dec.sel_store,
        busy_reg && st_sel_store_reg, "store read not staged")
    // the stage never overflows into a full output register
    `ASSERT_NEXT(a_stage_hold, busy_reg && !can_load && !in_acc,
        busy_reg && out_valid_reg, "staged beat dropped")
    // a config write of one turns the overlay off
    `ASSERT_NEXT(a_skip_overlay, cfg_wr && pwdata[0], !overlay_reg,
        "overlay still on after skip write")

endmodule

FILE: rtl/mmbd_ram.sv
module mmbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mmbd_decode.sv
module mmbd_decode (
    input  logic          [1:0]  func,
    input  logic          [15:0] address,
    input  logic          [7:0]  write_byte,
    input  logic                 overlay_on,
    input  logic          [7:0]  irq_flag,
    input  logic          [7:0]  irq_enable,
    output mmbd_pkg::dec_t       dec
);
    import mmbd_pkg::*;

    logic is_wr;
    logic is_fwd;

    assign is_wr  = (func == FN_WRITE);
    assign is_fwd = (address < ADDR_VRAM_END)
                 || (address >= ADDR_LCD_LO && address <= ADDR_LCD_HI)
                 || (address == ADDR_BGP);

    always_comb
    begin
        dec             = '0;
        dec.status      = ST_LOCAL;
        dec.ram_addr    = address;
        dec.overlay_val = (write_byte == 8'h00);
        case (func)
            FN_LOAD:
            begin
                if (address >= ADDR_ROM_END)
                begin
                    dec.status  = ST_FAULT;
                    dec.rd_byte = FAULT_BYTE;
                end
                else
                begin
                    dec.ram_en = 1'b1;
                    dec.ram_we = 1'b1;
                end
            end
            FN_READ, FN_WRITE:
            begin
                if (address < ADDR_ROM_END)
                begin
                    if (is_wr)
                    begin
                        dec.status  = ST_FAULT;
                        dec.rd_byte = FAULT_BYTE;
                    end
                    else if (overlay_on && address < 16'(BOOT_ROM_BYTES))
                    begin
                        dec.rd_byte = BOOT_TABLE[address[BOOT_IDX_W-1:0]];
                    end
                    else
                    begin
                        dec.ram_en    = 1'b1;
                        dec.sel_store = 1'b1;
                    end
                end
                else if (is_fwd)
                begin
                    dec.status   = ST_FWD;
                    dec.fwd_addr = address;
                    dec.fwd_byte = is_wr ? write_byte : 8'h00;
                end
                else if (address >= ADDR_MIRROR_LO && address < ADDR_MIRROR_END)
                begin
                    dec.ram_addr  = address - MIRROR_OFFSET;
                    dec.ram_en    = 1'b1;
                    dec.ram_we    = is_wr;
                    dec.sel_store = !is_wr;
                end
                else if (address >= ADDR_UNUSED_LO && address < ADDR_IO_LO)
                begin
                    dec.status  = ST_FAULT;
                    dec.rd_byte = FAULT_BYTE;
                end
                else if (address == ADDR_IF)
                begin
                    dec.set_flag = is_wr;
                    dec.rd_byte  = is_wr ? 8'h00 : irq_flag;
                end
                else if (address == ADDR_IE)
                begin
                    dec.set_enable = is_wr;
                    dec.rd_byte    = is_wr ? 8'h00 : irq_enable;
                end
                else
                begin
                    dec.set_overlay = is_wr && (address == ADDR_BOOT_OFF);
                    dec.ram_en      = 1'b1;
                    dec.ram_we      = is_wr;
                    dec.sel_store   = !is_wr;
                end
            end
            default:
            begin
                dec.status  = ST_FAULT;
                dec.rd_byte = FAULT_BYTE;
            end
        endcase
    end

endmodule
